// ----- hdl/mpf_pkg.sv -----
`default_nettype none
package mpf_pkg;
    localparam int FREQ_W     = 16;
    localparam int RATE_W     = 24;
    localparam int PPT_W      = 8;
    localparam int CMD_W      = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_STEPS  = 24;
    localparam int DIV_CNT_W  = 5;
    localparam int BIT_IDX_W  = 4;

    localparam logic [FREQ_W-1:0] FREQ_MAX = 16'hFFFF;
    localparam logic [PPT_W-1:0]  PPT_RESET = 8'd6;
    localparam logic [RATE_W-1:0] RATE_RESET = 24'd250000;

    typedef enum logic [CMD_W-1:0] {
        CMD_EDGE  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    localparam logic CFG_IDX_PPT  = 1'b0;
    localparam logic CFG_IDX_RATE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_WRITE,
        S_MED_GO,
        S_MED_WAIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              start;
        logic [RATE_W-1:0] dividend;
        logic [FREQ_W-1:0] divisor;
    } t_div_req;
endpackage
`default_nettype wire

// ----- hdl/mpf_in_if.sv -----
`default_nettype none
interface mpf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] timer_count;
    logic        state_value;
    modport source (output valid, command, timer_count, state_value, input ready);
    modport sink   (input valid, command, timer_count, state_value, output ready);
endinterface
`default_nettype wire

// ----- hdl/mpf_out_if.sv -----
`default_nettype none
interface mpf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] recent_freq;
    logic [15:0] median_freq;
    modport source (output valid, recent_freq, median_freq, input ready);
    modport sink   (input valid, recent_freq, median_freq, output ready);
endinterface
`default_nettype wire

// ----- hdl/mpf_ram.sv -----
`default_nettype none
module mpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/mpf_div.sv -----
`default_nettype none
module mpf_div
    import mpf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_div_req          i_req,
    output logic                   o_done,
    output logic [FREQ_W-1:0]      o_quot
);
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [FREQ_W-1:0]    r_rem;
    logic [RATE_W-1:0]    r_quo;
    logic [FREQ_W-1:0]    r_dvs;
    logic [FREQ_W:0]      shifted;
    logic                 fits;

    // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
    assign shifted = {r_rem, r_quo[RATE_W-1]};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= fits ? FREQ_W'(shifted - {1'b0, r_dvs}) : shifted[FREQ_W-1:0];
                r_quo <= {r_quo[RATE_W-2:0], fits};
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;

    always_comb begin
        if (r_dvs == '0 || r_quo[RATE_W-1:FREQ_W] != '0) begin
            o_quot = FREQ_MAX;
        end else begin
            o_quot = r_quo[FREQ_W-1:0];
        end
    end
endmodule
`default_nettype wire

// ----- hdl/mpf_sel.sv -----
`default_nettype none
module mpf_sel
    import mpf_pkg::*;
#(
    parameter int WINDOW = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    output logic [$clog2(WINDOW)-1:0]      o_raddr,
    input  wire logic [FREQ_W-1:0]         i_elem,
    output logic                           o_done,
    output logic [FREQ_W-1:0]              o_median
);
    localparam int AW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [CW-1:0] KSEL = CW'(WINDOW / 2);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_p;
    logic [BIT_IDX_W-1:0] r_b;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_krem;
    logic [FREQ_W-1:0]    r_prefix;
    logic [FREQ_W-1:0]    mask;
    logic                 match;
    logic [CW-1:0]        sum;

    // Radix selection: each pass over the ring fixes one bit of the answer,
    // counting the entries that share the known upper bits and have a zero here.
    assign mask  = FREQ_MAX << r_b;
    assign match = (r_p != '0) && ((i_elem & mask) == r_prefix);
    assign sum   = r_cnt + CW'(match);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_p      <= '0;
                r_b      <= '1;
                r_cnt    <= '0;
                r_krem   <= KSEL;
                r_prefix <= '0;
            end else if (r_busy) begin
                if (r_p == CW'(WINDOW)) begin
                    if (r_krem >= sum) begin
                        r_prefix <= r_prefix | (FREQ_W'(1) << r_b);
                        r_krem   <= r_krem - sum;
                    end
                    r_cnt <= '0;
                    r_p   <= '0;
                    if (r_b == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_b <= r_b - 1'b1;
                    end
                end else begin
                    r_p   <= r_p + 1'b1;
                    r_cnt <= sum;
                end
            end
        end
    end

    assign o_raddr  = r_p[AW-1:0];
    assign o_done   = r_done;
    assign o_median = r_prefix;
endmodule
`default_nettype wire

// ----- hdl/motor_pulse_frequency_median_core.sv -----
`default_nettype none
// Tachometer speed meter with a median filter over the last WINDOW readings.
// Requests arrive on i_in (command, timer_count, state_value); every request
// gives exactly one response on o_out (recent_freq, median_freq), zero for
// pulse edges and state changes. Configuration is written through i_cfg_we,
// i_cfg_idx (0 pulses per turn, 1 tick rate) and i_cfg_data; the user must
// write it only while idle, as the block does not enforce this. One request
// is worked at a time; i_in.ready is high only when idle. A pulse edge runs
// the 24-step shared restoring divider. A query while running runs the
// divider, then one pass over the ring memory per bit of the 16-bit median.
// The response sits in an output register; when the receiver stalls, the
// finished request waits in S_FIN until that register is free, and the next
// request is not taken before then. Synchronous reset restores the
// configuration defaults, marks the motor running and empties the ring; ring
// entries never written read as zero.
module motor_pulse_frequency_median_core
    import mpf_pkg::*;
#(
    parameter int WINDOW = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    mpf_in_if.sink                     i_in,
    mpf_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int AW = $clog2(WINDOW);

    t_state r_state, n_state;

    logic [PPT_W-1:0]  r_ppt;
    logic [RATE_W-1:0] r_rate;
    logic [PPT_W-1:0]  r_pulse;
    logic [FREQ_W-1:0] r_ticks;
    logic              r_run;
    logic [WINDOW-1:0] r_valid;
    logic [AW-1:0]     r_idx;
    logic              r_vld_q;
    logic              r_is_query;
    logic [FREQ_W-1:0] r_freq;
    logic [FREQ_W-1:0] r_res_recent;
    logic [FREQ_W-1:0] r_res_median;
    logic              r_out_valid;
    logic [FREQ_W-1:0] r_out_recent;
    logic [FREQ_W-1:0] r_out_median;

    logic              accept;
    logic [PPT_W-1:0]  pulse_inc;
    t_div_req          div_req;
    logic              div_done;
    logic [FREQ_W-1:0] div_quot;
    logic              sel_start;
    logic              sel_done;
    logic [AW-1:0]     sel_raddr;
    logic [FREQ_W-1:0] sel_median;
    logic [FREQ_W-1:0] ram_rdata;
    logic [FREQ_W-1:0] elem;
    logic              ring_we;
    logic              out_free;

    assign accept    = i_in.valid && i_in.ready;
    assign pulse_inc = r_pulse + 1'b1;
    assign out_free  = !r_out_valid || o_out.ready;
    assign ring_we   = (r_state == S_WRITE);
    assign sel_start = (r_state == S_MED_GO);
    assign elem      = r_vld_q ? ram_rdata : '0;

    assign div_req.start    = (r_state == S_DIV_GO);
    assign div_req.dividend = r_rate;
    assign div_req.divisor  = r_ticks;

    mpf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    mpf_ram #(.WIDTH(FREQ_W), .DEPTH(WINDOW)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_idx),
        .i_wdata (r_freq),
        .i_raddr (sel_raddr),
        .o_rdata (ram_rdata)
    );

    mpf_sel #(.WINDOW(WINDOW)) u_sel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (sel_start),
        .o_raddr  (sel_raddr),
        .i_elem   (elem),
        .o_done   (sel_done),
        .o_median (sel_median)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_in.ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    priority case (i_in.command)
                        CMD_EDGE:  n_state = S_DIV_GO;
                        CMD_QUERY: n_state = r_run ? S_DIV_GO : S_FIN;
                        default:   n_state = S_FIN;
                    endcase
                end
            end
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = r_is_query ? S_MED_GO : S_WRITE;
                end
            end
            S_WRITE:    n_state = S_FIN;
            S_MED_GO:   n_state = S_MED_WAIT;
            S_MED_WAIT: begin
                if (sel_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppt       <= PPT_RESET;
            r_rate      <= RATE_RESET;
            r_pulse     <= '0;
            r_ticks     <= '0;
            r_run       <= 1'b1;
            r_valid     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_PPT) begin
                    r_ppt <= i_cfg_data[PPT_W-1:0];
                end else begin
                    r_rate <= i_cfg_data[RATE_W-1:0];
                end
            end

            if (accept) begin
                r_is_query   <= (i_in.command == CMD_QUERY);
                r_res_recent <= '0;
                r_res_median <= '0;
                if (i_in.command == CMD_EDGE) begin
                    if (pulse_inc == r_ppt) begin
                        r_ticks <= i_in.timer_count;
                        r_pulse <= '0;
                        r_run   <= 1'b1;
                    end else begin
                        r_pulse <= pulse_inc;
                    end
                end else if (i_in.command == CMD_SET) begin
                    r_run <= i_in.state_value;
                end
            end

            if (r_state == S_DIV_WAIT && div_done) begin
                r_freq <= r_run ? div_quot : '0;
            end

            if (ring_we) begin
                r_valid[r_idx] <= 1'b1;
                r_idx <= (r_idx == AW'(WINDOW - 1)) ? '0 : r_idx + 1'b1;
            end

            if (r_state == S_MED_WAIT && sel_done) begin
                r_res_recent <= r_freq;
                r_res_median <= sel_median;
            end

            if (r_state == S_FIN && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_recent <= r_res_recent;
                r_out_median <= r_res_median;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The valid bit is registered alongside the memory read, so both refer to the same address.
    always_ff @(posedge i_clk) begin
        r_vld_q <= r_valid[sel_raddr];
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.recent_freq = r_out_recent;
    assign o_out.median_freq = r_out_median;
endmodule
`default_nettype wire
